// File: hdl/nlba_pkg.sv
package nlba_pkg;

   localparam int LANES      = 32;
   localparam int LANE_W     = 5;
   localparam int CODES      = 16;
   localparam int CODE_W     = 4;
   localparam int QUERY_W    = 14;
   localparam int QUERIES    = 4;
   localparam int ENTRY_W    = 15;
   localparam int ROW_W      = CODES * ENTRY_W;
   localparam int VMIN_W     = 17;
   localparam int ACC_W      = 23;
   localparam int SHIFT_W    = 24;
   localparam int GRP_W      = 8;
   localparam int CODE_WORD_W = 128;

   localparam int REQ_DATA_W = 192;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;

   // tuser bit positions on the request side
   localparam int USER_MODE  = 0;
   localparam int USER_FIRST = 1;

   localparam logic [ENTRY_W-1:0]   ENTRY_MAX = 15'h7FFF;
   localparam logic [ACC_W-1:0]     ACC_MAX   = 23'h7FFFFF;
   localparam logic [SHIFT_W-1:0]   SHIFT_MIN = 24'h800000;
   localparam logic [LANE_W-1:0]    LAST_LANE = 5'd31;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_CODES = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD,
      ST_ACCUM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic add;
   } lane_ctrl_type;

   typedef struct packed {
      logic busy;
   } emit_stat_type;

endpackage

// File: hdl/nlba_lut_gen.sv
module nlba_lut_gen #(
   parameter int QUERY_BITS = 14
) (
   input  logic                                    clock,
   input  logic                                    capture,
   input  logic [nlba_pkg::QUERY_W-1:0]            query_raw [nlba_pkg::QUERIES],
   output logic [nlba_pkg::ROW_W-1:0]              row,
   output logic signed [nlba_pkg::VMIN_W-1:0]      vmin
);
   import nlba_pkg::*;

   localparam int Sh = QUERY_W - QUERY_BITS;

   logic signed [QUERY_W-1:0] q_in [QUERIES];
   logic signed [QUERY_W-1:0] q_ff [QUERIES];
   logic signed [VMIN_W-1:0]  vmin_in;
   logic signed [VMIN_W-1:0]  vmin_ff;
   logic signed [QUERY_W-1:0] shl  [QUERIES];

   // sign-extend the low QUERY_BITS bits, sum of the negative ones
   always_comb begin
      vmin_in = '0;
      for (int k = 0; k < QUERIES; k++) begin
         shl[k]  = $signed(query_raw[k] << Sh);
         q_in[k] = shl[k] >>> Sh;
         if (q_in[k] < 0) begin
            vmin_in = vmin_in + VMIN_W'(q_in[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         q_ff    <= q_in;
         vmin_ff <= vmin_in;
      end
   end

   // entry c: -vmin + subset picked by c (bit 3 -> q0 ... bit 0 -> q3)
   always_comb begin
      logic signed [VMIN_W:0] e;
      for (int c = 0; c < CODES; c++) begin
         e = -(VMIN_W+1)'(vmin_ff);
         for (int k = 0; k < QUERIES; k++) begin
            if (c[QUERIES-1-k]) begin
               e = e + (VMIN_W+1)'(q_ff[k]);
            end
         end
         if (e > $signed({3'b000, ENTRY_MAX})) begin
            row[c*ENTRY_W +: ENTRY_W] = ENTRY_MAX;
         end else begin
            row[c*ENTRY_W +: ENTRY_W] = e[ENTRY_W-1:0];
         end
      end
   end

   assign vmin = vmin_ff;

endmodule

// File: hdl/nlba_lane.sv
module nlba_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  nlba_pkg::lane_ctrl_type       ctrl,
   input  logic [nlba_pkg::CODE_W-1:0]   code,
   input  logic [nlba_pkg::ROW_W-1:0]    row,
   output logic [nlba_pkg::ACC_W-1:0]    acc
);
   import nlba_pkg::*;

   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   acc_in;
   logic [ACC_W-1:0]   base;
   logic [ENTRY_W-1:0] entry;
   logic [ACC_W:0]     sum;

   always_comb begin
      entry = row[code*ENTRY_W +: ENTRY_W];
      base  = ctrl.clear ? '0 : acc_ff;
      sum   = {1'b0, base} + (ACC_W+1)'(entry);
      if (!ctrl.add) begin
         acc_in = base;
      end else if (sum[ACC_W]) begin
         acc_in = ACC_MAX;
      end else begin
         acc_in = sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// File: hdl/nlba_emit.sv
module nlba_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [nlba_pkg::ACC_W-1:0]        sums [nlba_pkg::LANES],
   input  logic [nlba_pkg::SHIFT_W-1:0]      shift,
   output nlba_pkg::emit_stat_type           stat,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [nlba_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import nlba_pkg::*;

   logic               active_ff, active_in;
   logic [LANE_W-1:0]  cnt_ff, cnt_in;
   logic               vld_ff, vld_in;
   logic [LANE_W-1:0]  idx_ff;
   logic [ACC_W-1:0]   sum_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic               last_ff;
   logic               load;

   always_comb begin
      load      = active_ff && (!vld_ff || rsp_tready);
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
      end else if (load) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_LANE) begin
            active_in = 1'b0;
         end
      end
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         vld_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         idx_ff   <= cnt_ff;
         sum_ff   <= sums[cnt_ff];
         shift_ff <= shift;
         last_ff  <= (cnt_ff == LAST_LANE);
      end
   end

   assign stat.busy  = active_ff;
   assign rsp_tvalid = vld_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {4'b0000, shift_ff, sum_ff, idx_ff};

`ifndef NO_ASSERTIONS
   a_last_tag: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> ((idx_ff == LAST_LANE) == last_ff))
      else $error("last flag does not match lane index");
   a_start: assert property (@(posedge clock) disable iff (reset)
      start |=> (active_ff && cnt_ff == '0))
      else $error("readout did not start at lane zero");
   a_stop: assert property (@(posedge clock) disable iff (reset)
      (load && cnt_ff == LAST_LANE && !start) |=> !active_ff)
      else $error("readout kept running past the final lane");
`endif

endmodule

// File: hdl/nibble_lut_build_and_accumulate_top.sv
// Table-load request: capture, then table row write and shift update.
// Code request: table row read, then 32 lane adds; a code request
//   flagged last adds 32 results, one result per cycle while rsp_tready holds.
// One request in flight at a time.
// Reset (synchronous, active high) clears control, lane sums and shift; the table
//   holds no defined value until its group is loaded, and needs no clearing pass.
module nibble_lut_build_and_accumulate_top #(
   parameter int MAX_GROUPS = 256,
   parameter int QUERY_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: group_index[7:0], query_comp0[21:8], query_comp1[35:22],
   //        query_comp2[49:36], query_comp3[63:50], code_bytes_low[127:64],
   //        code_bytes_high[191:128]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nlba_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: mode[0], first_item[1]
   input  logic [nlba_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                              req_tlast,   // last_item
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: vector_index[4:0], raw_sum[27:5], min_shift[51:28], zero pad
   output logic [nlba_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast    // last_result
);
   import nlba_pkg::*;

   localparam int AddrW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

   // ---------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------
   logic                  req_fire;
   logic [10:0]           grp_ext;
   logic                  grp_ok;
   logic [QUERY_W-1:0]    query_raw [QUERIES];

   assign req_fire = req_tvalid && req_tready;
   assign grp_ext  = {3'b000, req_tdata[GRP_W-1:0]};
   assign grp_ok   = (grp_ext < 11'(MAX_GROUPS));

   always_comb begin
      for (int k = 0; k < QUERIES; k++) begin
         query_raw[k] = req_tdata[GRP_W + k*QUERY_W +: QUERY_W];
      end
   end

   // Latched request fields
   logic                    mode_ff, first_ff, last_ff, grp_ok_ff;
   logic [AddrW-1:0]        addr_ff;
   logic [CODE_WORD_W-1:0]  codes_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff   <= req_tuser[USER_MODE];
         first_ff  <= req_tuser[USER_FIRST];
         last_ff   <= req_tlast;
         grp_ok_ff <= grp_ok;
         addr_ff   <= grp_ext[AddrW-1:0];
         codes_ff  <= req_tdata[REQ_DATA_W-1 -: CODE_WORD_W];
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   state_type      state_ff, state_in;
   lane_ctrl_type  lane_ctrl;
   emit_stat_type  emit_stat;
   logic           build_we;
   logic           emit_start;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[USER_MODE] == MODE_CODES) begin
                  state_in = ST_ACCUM;
               end else if (grp_ok) begin
                  state_in = ST_BUILD;   // out-of-range load is dropped
               end
            end
         end
         ST_BUILD: state_in = ST_IDLE;
         ST_ACCUM: state_in = last_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (!emit_stat.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      build_we        = 1'b0;
      emit_start      = 1'b0;
      lane_ctrl.clear = 1'b0;
      lane_ctrl.add   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_BUILD: build_we = 1'b1;
         ST_ACCUM: begin
            lane_ctrl.clear = first_ff;
            lane_ctrl.add   = grp_ok_ff;   // out-of-range group adds nothing
            emit_start      = last_ff;
         end
         ST_EMIT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // Table build: query values -> one 16-entry row per group
   // ---------------------------------------------------------------
   logic [ROW_W-1:0]          build_row;
   logic signed [VMIN_W-1:0]  vmin;

   nlba_lut_gen #(
      .QUERY_BITS(QUERY_BITS)
   ) u_lut_gen (
      .clock     (clock),
      .capture   (req_fire),
      .query_raw (query_raw),
      .row       (build_row),
      .vmin      (vmin)
   );

   // Group table: one wide row per group, one write or one read per cycle.
   logic [ROW_W-1:0] table_mem [MAX_GROUPS];
   logic [ROW_W-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (build_we) begin
         table_mem[addr_ff] <= build_row;
      end
      if (req_fire && req_tuser[USER_MODE] == MODE_CODES && grp_ok) begin
         rd_row_ff <= table_mem[grp_ext[AddrW-1:0]];
      end
   end

   // Running shift: sum of per-group minima, floors at the 24-bit minimum.
   logic [SHIFT_W-1:0]          shift_ff, shift_in;
   logic signed [SHIFT_W:0]     shift_sum;
   logic signed [SHIFT_W-1:0]   shift_base;
   localparam logic signed [SHIFT_W:0] ShiftFloor = -25'sd8388608;

   always_comb begin
      shift_base = first_ff ? '0 : $signed(shift_ff);
      shift_sum  = (SHIFT_W+1)'(shift_base) + (SHIFT_W+1)'(vmin);
      shift_in   = shift_ff;
      if (build_we) begin
         if (shift_sum < ShiftFloor) begin
            shift_in = SHIFT_MIN;
         end else begin
            shift_in = shift_sum[SHIFT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else begin
         shift_ff <= shift_in;
      end
   end

   // ---------------------------------------------------------------
   // 32 lanes. Code byte k: low nibble -> lane k, high nibble -> lane k+16.
   // ---------------------------------------------------------------
   logic [ACC_W-1:0] lane_sum [LANES];

   for (genvar n = 0; n < LANES; n++) begin : g_lane
      localparam int ByteIdx = n % 16;
      localparam int NibIdx  = n / 16;

      nlba_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (lane_ctrl),
         .code  (codes_ff[ByteIdx*8 + NibIdx*CODE_W +: CODE_W]),
         .row   (rd_row_ff),
         .acc   (lane_sum[n])
      );
   end

   // ---------------------------------------------------------------
   // Merge: lane sums read out one per cycle while rsp_tready holds, through the output register
   // ---------------------------------------------------------------
   nlba_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (emit_start),
      .sums       (lane_sum),
      .shift      (shift_ff),
      .stat       (emit_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !emit_stat.busy)
      else $error("request port open while readout still running");
   a_build_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUILD) |-> grp_ok_ff)
      else $error("table row written for out-of-range group");
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      emit_start |=> (emit_stat.busy && state_ff == ST_EMIT))
      else $error("readout not running after last code request");
`endif

endmodule

// File: tb/sv/nibble_lut_build_and_accumulate_top_tb.sv
module nibble_lut_build_and_accumulate_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nlba_pkg::*;

   // 8-bit group index, so with the default 256 groups every index is in range
   localparam int N_GROUPS   = 256;
   localparam int RAND_REQS  = 176;   // random requests after the directed rows
   localparam int SAT_RUN    = 16;    // length of the deep-shift and large-entry runs
   localparam int SAT_GROUP  = 7;
   localparam int DRAIN_CYC  = 40;
   localparam int MAX_SHOWN  = 10;
   localparam int N_DIR      = 19;

   localparam logic [QUERY_W-1:0]     Q_MAX      = 14'h1FFF;   // +8191
   localparam logic [QUERY_W-1:0]     Q_MIN      = 14'h2000;   // -8192, overflows an entry
   localparam logic [QUERY_W-1:0]     Q_NEG      = 14'h2001;   // -8191
   localparam logic [CODE_WORD_W-1:0] CODES_ZERO = '0;
   localparam logic [CODE_WORD_W-1:0] CODES_ONES = '1;
   localparam logic [ACC_W-1:0]       BIG_SUM    = 23'd524272;  // 16 x 32767

   typedef struct packed {
      logic                     mode;
      logic [GRP_W-1:0]         grp;
      logic                     first_item;
      logic                     last_item;
      logic [QUERY_W-1:0]       q0, q1, q2, q3;
      logic [CODE_WORD_W-1:0]   codes;
   } lut_req_type;

   // directed row: request plus an optional hand-written sum/shift for all 32 lanes
   typedef struct packed {
      lut_req_type          req;
      logic                 fixed;
      logic [ACC_W-1:0]     raw;
      logic [SHIFT_W-1:0]   shift;
   } dir_row_type;

   typedef struct packed {
      logic [LANE_W-1:0]    lane;
      logic [ACC_W-1:0]     raw;
      logic [SHIFT_W-1:0]   shift;
      logic                 tail;
   } lane_sum_type;

   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      // zero table, zero shift
      '{'{MODE_LOAD,  8'd0,   1'b1, 1'b0, 14'h0, 14'h0, 14'h0, 14'h0, CODES_ZERO},
        1'b0, 23'd0, 24'h0},
      '{'{MODE_CODES, 8'd0,   1'b1, 1'b1, 14'h0, 14'h0, 14'h0, 14'h0,
          128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210}, 1'b1, 23'd0, 24'h0},
      // all +max: no shift, entry 15 = 4 * 8191
      '{'{MODE_LOAD,  8'd1,   1'b1, 1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, CODES_ZERO},
        1'b0, 23'd0, 24'h0},
      '{'{MODE_CODES, 8'd1,   1'b1, 1'b1, 14'h0, 14'h0, 14'h0, 14'h0, CODES_ONES},
        1'b1, 23'd32764, 24'h0},
      // all -8192: entry 0 saturates, shift -32768; last is ignored on a load
      '{'{MODE_LOAD,  8'd255, 1'b0, 1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, CODES_ONES},
        1'b0, 23'd0, 24'h0},
      '{'{MODE_CODES, 8'd255, 1'b1, 1'b1, 14'h0, 14'h0, 14'h0, 14'h0, CODES_ZERO},
        1'b1, 23'd32767, 24'hFF8000},
      '{'{MODE_CODES, 8'd255, 1'b1, 1'b1, 14'h0, 14'h0, 14'h0, 14'h0, CODES_ONES},
        1'b1, 23'd0, 24'hFF8000},
      // mixed signs, multi-group accumulation
      '{'{MODE_LOAD,  8'd2,   1'b1, 1'b0, Q_MAX, Q_MIN, 14'h0001, 14'h3FFF, CODES_ZERO},
        1'b0, 23'd0, 24'h0},
      '{'{MODE_LOAD,  8'd3,   1'b0, 1'b0, Q_NEG, 14'h0, Q_MAX, Q_MIN, CODES_ZERO},
        1'b0, 23'd0, 24'h0},
      '{'{MODE_LOAD,  8'd128, 1'b0, 1'b0, 14'h2AAA, 14'h1555, 14'h3FFF, 14'h0001,
          CODES_ZERO}, 1'b0, 23'd0, 24'h0},
      '{'{MODE_CODES, 8'd2,   1'b1, 1'b0, 14'h0, 14'h0, 14'h0, 14'h0,
          128'h1E2D_3C4B_5A69_7887_96A5_B4C3_D2E1_F00F}, 1'b0, 23'd0, 24'h0},
      '{'{MODE_CODES, 8'd3,   1'b0, 1'b0, 14'h0, 14'h0, 14'h0, 14'h0, {16{8'hA5}}},
        1'b0, 23'd0, 24'h0},
      '{'{MODE_CODES, 8'd128, 1'b0, 1'b1, 14'h0, 14'h0, 14'h0, 14'h0, {8{16'hF00F}}},
        1'b0, 23'd0, 24'h0},
      // no clear: sums carry over from the previous emission
      '{'{MODE_CODES, 8'd1,   1'b0, 1'b1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, CODES_ZERO},
        1'b0, 23'd0, 24'h0},
      '{'{MODE_CODES, 8'd0,   1'b1, 1'b1, 14'h0, 14'h0, 14'h0, 14'h0, CODES_ONES},
        1'b0, 23'd0, 24'h0},
      // all -1: shift restarts at -4, entry c = 4 - popcount(c)
      '{'{MODE_LOAD,  8'd4,   1'b1, 1'b1, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF,
          CODES_ZERO}, 1'b0, 23'd0, 24'h0},
      '{'{MODE_CODES, 8'd4,   1'b1, 1'b1, 14'h0, 14'h0, 14'h0, 14'h0, CODES_ZERO},
        1'b1, 23'd4, 24'hFFFFFC},
      '{'{MODE_CODES, 8'd4,   1'b1, 1'b0, 14'h0, 14'h0, 14'h0, 14'h0, CODES_ONES},
        1'b0, 23'd0, 24'h0},
      '{'{MODE_CODES, 8'd0,   1'b0, 1'b1, 14'h0, 14'h0, 14'h0, 14'h0, {16{8'h5A}}},
        1'b1, 23'd0, 24'hFFFFFC}
   };

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [REQ_USER_W-1:0]   req_tuser  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;

   // shadow of the engine: table rows, lane sums, running shift
   logic [ENTRY_W-1:0]  lut_rows [N_GROUPS][CODES];
   bit                  group_loaded [N_GROUPS];
   int                  live_groups [$];   // groups safe to read
   logic [ACC_W-1:0]    lane_acc [LANES] = '{default: '0};
   logic [SHIFT_W-1:0]  shift_acc = '0;
   lane_sum_type        due_sums [$];

   int       burst_left = 0;
   bit       idle_on    = 1'b0;
   int       n_loads    = 0;
   int       n_codes    = 0;
   int       n_checked  = 0;
   int       fail_count = 0;
   int       rx_cycle   = 0;
   logic [31:0] ready_pat = '1;

   nibble_lut_build_and_accumulate_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial forever #5 clock = ~clock;

   // hard stop well past the slowest legal run
   initial begin
      #5_000_000;
      $display("FAIL nibble_lut_build_and_accumulate_top");
      $finish;
   end

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ENTRY_W-1:0] b);
      logic [ACC_W:0] t;
      t = a + b;
      return (t > ACC_MAX) ? ACC_MAX : t[ACC_W-1:0];
   endfunction

   // Apply one accepted request to the shadow state; queue 32 sums on a last code request.
   task automatic fold_request(input lut_req_type r, input logic fixed,
                               input logic [ACC_W-1:0] fixed_raw,
                               input logic [SHIFT_W-1:0] fixed_shift);
      int           q [4];
      int           vmin;
      int           e;
      int           s;
      int           c;
      int           k;
      logic [7:0]   code_byte;
      lane_sum_type res;
      if (r.mode == MODE_LOAD) begin
         q[0] = $signed(r.q0);
         q[1] = $signed(r.q1);
         q[2] = $signed(r.q2);
         q[3] = $signed(r.q3);
         vmin = 0;
         for (k = 0; k < QUERIES; k++)
            if (q[k] < 0) vmin += q[k];
         // code bit 3 picks q0 ... bit 0 picks q3, biased by -vmin so entries are >= 0
         for (c = 0; c < CODES; c++) begin
            e = -vmin + ((c & 8) ? q[0] : 0) + ((c & 4) ? q[1] : 0)
                      + ((c & 2) ? q[2] : 0) + ((c & 1) ? q[3] : 0);
            if (e > int'(ENTRY_MAX)) e = int'(ENTRY_MAX);
            lut_rows[r.grp][c] = e[ENTRY_W-1:0];
         end
         if (r.first_item) shift_acc = '0;
         s = $signed(shift_acc) + vmin;
         if (s < $signed(SHIFT_MIN)) s = $signed(SHIFT_MIN);
         shift_acc = s[SHIFT_W-1:0];
         if (!group_loaded[r.grp]) begin
            group_loaded[r.grp] = 1'b1;
            live_groups.push_back(int'(r.grp));
         end
      end else begin
         if (r.first_item) lane_acc = '{default: '0};
         // byte k: low nibble -> lane k, high nibble -> lane k+16
         for (k = 0; k < CODES; k++) begin
            code_byte = r.codes[8*k +: 8];
            lane_acc[k]         = sat_add(lane_acc[k], lut_rows[r.grp][code_byte[3:0]]);
            lane_acc[k + CODES] = sat_add(lane_acc[k + CODES],
                                          lut_rows[r.grp][code_byte[7:4]]);
         end
         if (r.last_item)
            for (k = 0; k < LANES; k++) begin
               res.lane  = k[LANE_W-1:0];
               res.raw   = fixed ? fixed_raw : lane_acc[k];
               res.shift = fixed ? fixed_shift : shift_acc;
               res.tail  = (k == LANES - 1);
               due_sums.push_back(res);
            end
      end
   endtask

   function automatic logic [QUERY_W-1:0] pick_query();
      case ($urandom_range(0, 7))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return Q_NEG;
         3:       return '0;
         4:       return QUERY_W'($urandom_range(1, 64));
         5:       return QUERY_W'(-$urandom_range(1, 64));
         default: return QUERY_W'($urandom());
      endcase
   endfunction

   function automatic logic [CODE_WORD_W-1:0] pick_codes();
      case ($urandom_range(0, 5))
         0:       return CODES_ZERO;
         1:       return CODES_ONES;
         2:       return {32{4'($urandom_range(0, 15))}};
         default: return {$urandom(), $urandom(), $urandom(), $urandom()};
      endcase
   endfunction

   // unused fields (last on a load, codes on a load, queries on codes) carry noise
   function automatic lut_req_type load_req(input int g, input logic fst);
      lut_req_type r;
      r.mode       = MODE_LOAD;
      r.grp        = g[GRP_W-1:0];
      r.first_item = fst;
      r.last_item  = 1'($urandom_range(0, 1));
      r.q0         = pick_query();
      r.q1         = pick_query();
      r.q2         = pick_query();
      r.q3         = pick_query();
      r.codes      = pick_codes();
      return r;
   endfunction

   function automatic lut_req_type code_req(input int g, input logic fst, input logic lst);
      lut_req_type r;
      r = load_req(g, fst);
      r.mode      = MODE_CODES;
      r.last_item = lst;
      return r;
   endfunction

   // Drive one request at a clock edge and hold it until taken; bursts with random gaps.
   task automatic send(input lut_req_type r, input logic fixed = 1'b0,
                       input logic [ACC_W-1:0] fixed_raw = '0,
                       input logic [SHIFT_W-1:0] fixed_shift = '0);
      int                    gap;
      logic [REQ_USER_W-1:0] user;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = idle_on ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      user             = '0;
      user[USER_MODE]  = r.mode;
      user[USER_FIRST] = r.first_item;
      req_tvalid <= 1'b1;
      req_tdata  <= {r.codes, r.q3, r.q2, r.q1, r.q0, r.grp};
      req_tuser  <= user;
      req_tlast  <= r.last_item;
      do @(posedge clock); while (!req_tready);
      fold_request(r, fixed, fixed_raw, fixed_shift);
      if (r.mode == MODE_LOAD) n_loads++;
      else n_codes++;
   endtask

   // Result side: own random stall pattern; checks each taken sum.
   always @(posedge clock) begin
      lane_sum_type seen;
      lane_sum_type want;
      if (rx_cycle % 64 == 0)
         case ($urandom_range(0, 3))
            0:       ready_pat = '1;
            1:       ready_pat = 32'h1111_1111;
            default: ready_pat = $urandom() | 32'h0101_0101;
         endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.lane  = rsp_tdata[LANE_W-1:0];
         seen.raw   = rsp_tdata[LANE_W +: ACC_W];
         seen.shift = rsp_tdata[LANE_W + ACC_W +: SHIFT_W];
         seen.tail  = rsp_tlast;
         n_checked++;
         if (due_sums.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("unexpected sum: lane %0d raw %0d shift %0d last %0b",
                        seen.lane, seen.raw, $signed(seen.shift), seen.tail);
         end else begin
            want = due_sums.pop_front();
            if (seen.lane !== want.lane || seen.raw !== want.raw ||
                seen.shift !== want.shift || seen.tail !== want.tail) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display({"sum mismatch: want lane %0d raw %0d shift %0d last %0b,",
                            " got lane %0d raw %0d shift %0d last %0b"},
                           want.lane, want.raw, $signed(want.shift), want.tail,
                           seen.lane, seen.raw, $signed(seen.shift), seen.tail);
            end
         end
      end
      rsp_tready <= ready_pat[rx_cycle % 32];
      rx_cycle++;
   end

   initial begin
      int          i;
      int          g;
      int          n_ld;
      int          n_cd;
      int          rand_count;
      lut_req_type r;
      logic        fst;
      logic        lst;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows back to back
      for (i = 0; i < N_DIR; i++)
         send(DIR_ROWS[i].req, DIR_ROWS[i].fixed, DIR_ROWS[i].raw, DIR_ROWS[i].shift);

      // deep shift: a run of all -8192 loads, cleared only at the start
      idle_on = 1'b1;
      for (i = 0; i < SAT_RUN; i++) begin
         r = load_req($urandom_range(0, N_GROUPS - 1), i == 0);
         r.q0 = Q_MIN;
         r.q1 = Q_MIN;
         r.q2 = Q_MIN;
         r.q3 = Q_MIN;
         send(r);
      end
      send(code_req(live_groups[$urandom_range(0, live_groups.size() - 1)], 1'b1, 1'b1));

      // large entries: entry 0 = 32767, all zero codes, every lane adds it each time
      r = load_req(SAT_GROUP, 1'b1);
      r.q0 = Q_MIN;
      r.q1 = Q_MIN;
      r.q2 = Q_MIN;
      r.q3 = Q_MIN;
      send(r);
      for (i = 0; i < SAT_RUN; i++) begin
         r = code_req(SAT_GROUP, i == 0, i == SAT_RUN - 1);
         r.codes = CODES_ZERO;
         if (i == SAT_RUN - 1) send(r, 1'b1, BIG_SUM, 24'hFF8000);   // one -32768 load
         else send(r);
      end

      // random frames: loads, a run of code requests over loaded groups, stray loads,
      // occasional missing clears and early emissions
      rand_count = 0;
      while (rand_count < RAND_REQS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         n_ld = $urandom_range(0, 3);
         for (i = 0; i < n_ld; i++) begin
            send(load_req($urandom_range(0, N_GROUPS - 1),
                          i == 0 && $urandom_range(0, 7) != 0));
            rand_count++;
         end
         n_cd = $urandom_range(1, 8);
         for (i = 0; i < n_cd; i++) begin
            fst = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
            lst = (i == n_cd - 1) ? ($urandom_range(0, 7) != 0)
                                  : ($urandom_range(0, 15) == 0);
            g = live_groups[$urandom_range(0, live_groups.size() - 1)];
            send(code_req(g, fst, lst));
            rand_count++;
            if ($urandom_range(0, 11) == 0) begin
               send(load_req($urandom_range(0, N_GROUPS - 1), 1'b0));
               rand_count++;
            end
         end
      end

      req_tvalid <= 1'b0;
      while (due_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);

      $display("Ran %0d table loads and %0d code requests, with -8192 runs and stalls;",
               n_loads, n_codes);
      $display("%0d lane sums compared, %0d failures.", n_checked, fail_count);
      if (fail_count == 0 && due_sums.size() == 0)
         $display("PASS nibble_lut_build_and_accumulate_top");
      else
         $display("FAIL nibble_lut_build_and_accumulate_top");
      $finish;
   end

endmodule
